// ----- rtl/core/tgtl_pkg.sv -----
// ----------------------------------------------------------------------------
// tgtl_pkg
// Shared types, codes and constants of the thruster gain trim learner.
// ----------------------------------------------------------------------------
package tgtl_pkg;

	localparam int MOTOR_COUNT_DEF = 8;

	localparam int MODE_W     = 2;
	localparam int MOTOR_W    = 4;
	localparam int DUTY_W     = 16;
	localparam int SPEED_W    = 16;
	localparam int INTERVAL_W = 16;
	localparam int GAIN_W     = 15;
	localparam int OUTCOME_W  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int RPM_W      = 15;
	localparam int TAU_W      = 16;
	localparam int LIM_W      = 16;

	// divider: 33-bit dividend, 17-bit divisor, 17 quotient bits
	localparam int DVD_W  = 33;
	localparam int QUOT_W = 17;

	localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GAIN   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RAW    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

	localparam logic [OUTCOME_W-1:0] OUT_LEARNED   = 4'd0;
	localparam logic [OUTCOME_W-1:0] OUT_OFF       = 4'd1;
	localparam logic [OUTCOME_W-1:0] OUT_NO_TELEM  = 4'd2;
	localparam logic [OUTCOME_W-1:0] OUT_LOW_DUTY  = 4'd3;
	localparam logic [OUTCOME_W-1:0] OUT_TRANSIENT = 4'd4;
	localparam logic [OUTCOME_W-1:0] OUT_LOW_PRED  = 4'd5;
	localparam logic [OUTCOME_W-1:0] OUT_REVERSAL  = 4'd6;
	localparam logic [OUTCOME_W-1:0] OUT_ANSWERED  = 4'd7;
	localparam logic [OUTCOME_W-1:0] OUT_BAD_INDEX = 4'd8;
	localparam logic [OUTCOME_W-1:0] OUT_CLEARED   = 4'd9;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_RPM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TAU     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd3;

	localparam logic [GAIN_W-1:0] GAIN_ONE    = 15'd16384;
	localparam logic [RPM_W-1:0]  RPM_DEFAULT = 15'd3600;
	localparam logic [RPM_W-1:0]  RPM_MIN     = 15'd1;
	localparam logic [TAU_W-1:0]  TAU_DEFAULT = 16'd4000;
	localparam logic [TAU_W-1:0]  TAU_MIN     = 16'd200;
	localparam logic [LIM_W-1:0]  LIM_MAX     = 16'd58982;

	// thresholds scaled by twenty
	localparam int RATIO = 20;
	localparam logic [20:0] DUTY_MIN_X20 = 21'd98304;
	localparam logic [21:0] SLEW_MAX_X20 = 22'd32768;
	localparam logic [30:0] PRED_MIN     = 31'd32768;

	localparam logic [QUOT_W-1:0] TARGET_MIN = 17'd4096;
	localparam logic [QUOT_W-1:0] QUOT_SAT   = 17'd65536;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EVAL,
		S_TGT_GO,
		S_TGT_WAIT,
		S_STEP_GO,
		S_STEP_WAIT,
		S_MUL,
		S_ADJ,
		S_OUT
	} state_t;

	typedef enum logic {
		DIV_TARGET,
		DIV_STEP
	} div_sel_t;

	typedef struct packed {
		logic     capture;
		logic     eval;
		logic     div_start;
		div_sel_t div_sel;
		logic     tgt_load;
		logic     step_load;
		logic     mul;
		logic     adj;
		logic     res_load;
	} cmd_t;

	typedef struct packed {
		logic learn;
		logic div_done;
	} status_t;

endpackage

// ----- rtl/core/tgtl_div.sv -----
// ----------------------------------------------------------------------------
// tgtl_div
// Restoring divider, one quotient bit per cycle, quotient saturated at 1.0
// in Q1.16 (65536). A zero divisor also saturates.
// ----------------------------------------------------------------------------
module tgtl_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tgtl_pkg::DVD_W-1:0]  dividend,
	input  logic [tgtl_pkg::QUOT_W-1:0] divisor,
	output logic                        done,
	output logic [tgtl_pkg::QUOT_W-1:0] quot
);

	localparam int QW    = tgtl_pkg::QUOT_W;
	localparam int HI_W  = tgtl_pkg::DVD_W - QW;
	localparam int CNT_W = $clog2(QW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic [QW-1:0]    rem_q;
	logic [QW-1:0]    low_q;
	logic [QW-1:0]    quo_q;
	logic [QW-1:0]    dvs_q;

	logic [QW:0] rem_sh;
	logic [QW:0] rem_sub;
	logic        take;

	assign rem_sh  = {rem_q, low_q[QW-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign take    = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= QW'(dividend[tgtl_pkg::DVD_W-1:QW]);
			low_q <= dividend[QW-1:0];
			dvs_q <= divisor;
			ovf_q <= QW'(dividend[tgtl_pkg::DVD_W-1:QW]) >= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? rem_sub[QW-1:0] : rem_sh[QW-1:0];
			low_q <= {low_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], take};
		end
	end

	assign done = done_q;
	assign quot = (ovf_q || quo_q[QW-1]) ? tgtl_pkg::QUOT_SAT : quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");

endmodule

// ----- rtl/core/tgtl_ctrl.sv -----
// ----------------------------------------------------------------------------
// tgtl_ctrl
// Sequencer for one request at a time: evaluation, then for an update that
// learns two divisions on the shared divider, gain multiply and adjust;
// every request ends with hand-off to the result register.
// ----------------------------------------------------------------------------
module tgtl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	output logic              result_valid,
	input  logic              result_ready,
	output tgtl_pkg::cmd_t    cmd,
	input  tgtl_pkg::status_t status
);

	tgtl_pkg::state_t state_q;
	tgtl_pkg::state_t state_d;
	logic             result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= tgtl_pkg::S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.div_sel  = tgtl_pkg::DIV_TARGET;
		item_ready   = 1'b0;
		case (state_q)
			tgtl_pkg::S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = tgtl_pkg::S_EVAL;
				end
			end
			tgtl_pkg::S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = status.learn ? tgtl_pkg::S_TGT_GO : tgtl_pkg::S_OUT;
			end
			tgtl_pkg::S_TGT_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = tgtl_pkg::DIV_TARGET;
				state_d       = tgtl_pkg::S_TGT_WAIT;
			end
			tgtl_pkg::S_TGT_WAIT: begin
				if (status.div_done) begin
					cmd.tgt_load = 1'b1;
					state_d      = tgtl_pkg::S_STEP_GO;
				end
			end
			tgtl_pkg::S_STEP_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = tgtl_pkg::DIV_STEP;
				state_d       = tgtl_pkg::S_STEP_WAIT;
			end
			tgtl_pkg::S_STEP_WAIT: begin
				if (status.div_done) begin
					cmd.step_load = 1'b1;
					state_d       = tgtl_pkg::S_MUL;
				end
			end
			tgtl_pkg::S_MUL: begin
				cmd.mul = 1'b1;
				state_d = tgtl_pkg::S_ADJ;
			end
			tgtl_pkg::S_ADJ: begin
				cmd.adj = 1'b1;
				state_d = tgtl_pkg::S_OUT;
			end
			tgtl_pkg::S_OUT: begin
				if (!result_valid_q || result_ready) begin
					cmd.res_load = 1'b1;
					state_d      = tgtl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tgtl_pkg::S_IDLE;
			end
		endcase
	end

	assign result_valid = result_valid_q;

	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> state_q == tgtl_pkg::S_EVAL)
		else $error("accepted request not evaluated");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |->
			(state_q == tgtl_pkg::S_TGT_WAIT || state_q == tgtl_pkg::S_STEP_WAIT))
		else $error("division finished outside a wait state");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q) == tgtl_pkg::S_OUT)
		else $error("result raised outside the output state");

endmodule

// ----- rtl/core/tgtl_dp.sv -----
// ----------------------------------------------------------------------------
// tgtl_dp
// Datapath: configuration registers, request capture, gain and duty tables,
// acceptance checks, target and step divisions, gain update and result
// register.
// ----------------------------------------------------------------------------
module tgtl_dp #(
	parameter int MOTOR_COUNT = tgtl_pkg::MOTOR_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tgtl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tgtl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [tgtl_pkg::MODE_W-1:0]     mode,
	input  logic [tgtl_pkg::MOTOR_W-1:0]    motor,
	input  logic signed [tgtl_pkg::DUTY_W-1:0]  duty,
	input  logic signed [tgtl_pkg::SPEED_W-1:0] speed_rpm,
	input  logic                            telemetry_present,
	input  logic [tgtl_pkg::INTERVAL_W-1:0] interval_ms,
	input  logic                            learn_allowed,
	input  logic                            forward_band,
	input  tgtl_pkg::cmd_t                  cmd,
	output tgtl_pkg::status_t               status,
	output logic [tgtl_pkg::GAIN_W-1:0]     gain_value,
	output logic [tgtl_pkg::OUTCOME_W-1:0]  outcome,
	output logic                            band_used
);

	localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
	localparam int GW     = tgtl_pkg::GAIN_W;
	localparam int QW     = tgtl_pkg::QUOT_W;
	localparam int DW     = tgtl_pkg::DUTY_W;

	// configuration
	logic                       enable_q;
	logic [tgtl_pkg::RPM_W-1:0] full_rpm_q;
	logic [tgtl_pkg::TAU_W-1:0] tau_cfg_q;
	logic [tgtl_pkg::LIM_W-1:0] limit_q;

	// captured request
	logic [tgtl_pkg::MODE_W-1:0]     mode_q;
	logic [tgtl_pkg::MOTOR_W-1:0]    motor_q;
	logic [DW-1:0]                   duty_q;
	logic [tgtl_pkg::SPEED_W-1:0]    speed_q;
	logic                            present_q;
	logic [tgtl_pkg::INTERVAL_W-1:0] interval_q;
	logic                            allowed_q;
	logic                            fwd_q;

	// tables
	logic [GW-1:0] gain_q  [MOTOR_COUNT][2];
	logic [DW-1:0] pduty_q [MOTOR_COUNT];

	// working registers
	logic [GW-1:0]                  gain_res_q;
	logic [tgtl_pkg::OUTCOME_W-1:0] outcome_res_q;
	logic                           band_q;
	logic [30:0]                    num_q;
	logic [15:0]                    aspd_q;
	logic [QW-1:0]                  target_q;
	logic [QW-1:0]                  step_q;
	logic signed [35:0]             prod_q;

	// result register
	logic [GW-1:0]                  gain_out_q;
	logic [tgtl_pkg::OUTCOME_W-1:0] outcome_out_q;
	logic                           band_out_q;

	logic [MIDX_W-1:0] midx;
	logic              idx_ok;
	logic              band_e;
	logic [GW-1:0]     g_rd;
	logic [DW-1:0]     prev_rd;
	logic [15:0]       adur;
	logic [15:0]       aspd;
	logic signed [16:0] dslew;
	logic [16:0]       slew;
	logic [tgtl_pkg::RPM_W-1:0] rpm_full;
	logic [tgtl_pkg::TAU_W-1:0] tau;
	logic [30:0]       num;
	logic              is_reversal;

	logic [GW-1:0]                  eval_gain;
	logic [tgtl_pkg::OUTCOME_W-1:0] eval_outcome;
	logic                           eval_band;
	logic                           learn;
	logic                           pduty_wr;

	logic [tgtl_pkg::DVD_W-1:0] div_dvd;
	logic [QW-1:0]              div_dvs;
	logic                       div_done;
	logic [QW-1:0]              div_quot;

	logic [tgtl_pkg::LIM_W-1:0] lim16;
	logic [GW-1:0]              lim14;
	logic [GW-1:0]              g_lo;
	logic [GW-1:0]              g_hi;
	logic signed [17:0]         diff;
	logic signed [35:0]         prod_d;
	logic [35:0]                mag;
	logic [35:0]                mag_rnd;
	logic signed [21:0]         g_ext;
	logic signed [21:0]         adj;
	logic signed [21:0]         g_sum;
	logic [GW-1:0]              gain_new;

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			full_rpm_q <= tgtl_pkg::RPM_DEFAULT;
			tau_cfg_q  <= tgtl_pkg::TAU_DEFAULT;
			limit_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tgtl_pkg::CFG_ENABLE:   enable_q   <= cfg_data[0];
				tgtl_pkg::CFG_FULL_RPM: full_rpm_q <= cfg_data[tgtl_pkg::RPM_W-1:0];
				tgtl_pkg::CFG_TAU:      tau_cfg_q  <= cfg_data[tgtl_pkg::TAU_W-1:0];
				tgtl_pkg::CFG_LIMIT:    limit_q    <= cfg_data[tgtl_pkg::LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q     <= mode;
			motor_q    <= motor;
			duty_q     <= duty;
			speed_q    <= speed_rpm;
			present_q  <= telemetry_present;
			interval_q <= interval_ms;
			allowed_q  <= learn_allowed;
			fwd_q      <= forward_band;
		end
	end

	// evaluation
	assign midx     = motor_q[MIDX_W-1:0];
	assign idx_ok   = {1'b0, motor_q} < (tgtl_pkg::MOTOR_W + 1)'(MOTOR_COUNT);
	assign band_e   = (mode_q == tgtl_pkg::MODE_RAW) ? !fwd_q : duty_q[DW-1];
	assign g_rd     = gain_q[midx][band_e];
	assign prev_rd  = pduty_q[midx];
	assign adur     = duty_q[DW-1] ? (~duty_q + 16'd1) : duty_q;
	assign aspd     = speed_q[15] ? (~speed_q + 16'd1) : speed_q;
	assign dslew    = $signed({duty_q[DW-1], duty_q}) - $signed({prev_rd[DW-1], prev_rd});
	assign slew     = dslew[16] ? 17'(-dslew) : 17'(dslew);
	assign rpm_full = (full_rpm_q > tgtl_pkg::RPM_MIN) ? full_rpm_q : tgtl_pkg::RPM_DEFAULT;
	assign tau      = (tau_cfg_q > tgtl_pkg::TAU_MIN) ? tau_cfg_q : tgtl_pkg::TAU_DEFAULT;
	assign num      = 31'(rpm_full) * 31'(adur);
	assign is_reversal = (duty_q[DW-1] != speed_q[15]) &&
		(21'(aspd) * 21'(tgtl_pkg::RATIO) > 21'(rpm_full));

	always_comb begin
		eval_gain    = tgtl_pkg::GAIN_ONE;
		eval_outcome = tgtl_pkg::OUT_ANSWERED;
		eval_band    = band_e;
		learn        = 1'b0;
		pduty_wr     = 1'b0;
		if (mode_q == tgtl_pkg::MODE_CLEAR) begin
			eval_outcome = tgtl_pkg::OUT_CLEARED;
			eval_band    = 1'b0;
		end else if (!idx_ok) begin
			eval_outcome = tgtl_pkg::OUT_BAD_INDEX;
		end else begin
			case (mode_q)
				tgtl_pkg::MODE_RAW: begin
					eval_gain = g_rd;
				end
				tgtl_pkg::MODE_GAIN: begin
					if (enable_q) begin
						eval_gain = g_rd;
					end else begin
						eval_outcome = tgtl_pkg::OUT_OFF;
					end
				end
				default: begin
					pduty_wr  = 1'b1;
					eval_gain = g_rd;
					if (!enable_q || !allowed_q || interval_q == '0) begin
						eval_outcome = tgtl_pkg::OUT_OFF;
					end else if (!present_q) begin
						eval_outcome = tgtl_pkg::OUT_NO_TELEM;
					end else if (21'(adur) * 21'(tgtl_pkg::RATIO) < tgtl_pkg::DUTY_MIN_X20) begin
						eval_outcome = tgtl_pkg::OUT_LOW_DUTY;
					end else if (22'(slew) * 22'(tgtl_pkg::RATIO) > tgtl_pkg::SLEW_MAX_X20) begin
						eval_outcome = tgtl_pkg::OUT_TRANSIENT;
					end else if (num < tgtl_pkg::PRED_MIN) begin
						eval_outcome = tgtl_pkg::OUT_LOW_PRED;
					end else if (is_reversal) begin
						eval_outcome = tgtl_pkg::OUT_REVERSAL;
					end else begin
						eval_outcome = tgtl_pkg::OUT_LEARNED;
						learn        = 1'b1;
					end
				end
			endcase
		end
	end

	// gain and previous duty tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				gain_q[i][0] <= tgtl_pkg::GAIN_ONE;
				gain_q[i][1] <= tgtl_pkg::GAIN_ONE;
				pduty_q[i]   <= '0;
			end
		end else if (cmd.eval && mode_q == tgtl_pkg::MODE_CLEAR) begin
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				gain_q[i][0] <= tgtl_pkg::GAIN_ONE;
				gain_q[i][1] <= tgtl_pkg::GAIN_ONE;
				pduty_q[i]   <= '0;
			end
		end else begin
			if (cmd.eval && pduty_wr) begin
				pduty_q[midx] <= duty_q;
			end
			if (cmd.adj) begin
				gain_q[midx][band_q] <= gain_new;
			end
		end
	end

	// shared divider: target ratio, then learning step
	always_comb begin
		case (cmd.div_sel)
			tgtl_pkg::DIV_STEP: begin
				div_dvd = {1'b0, interval_q, 16'd0} + tgtl_pkg::DVD_W'(tau >> 1);
				div_dvs = QW'(tau);
			end
			default: begin
				div_dvd = tgtl_pkg::DVD_W'(num_q) + tgtl_pkg::DVD_W'(aspd_q);
				div_dvs = {aspd_q, 1'b0};
			end
		endcase
	end

	tgtl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (div_quot)
	);

	// gain update
	assign lim16  = (limit_q > tgtl_pkg::LIM_MAX) ? tgtl_pkg::LIM_MAX : limit_q;
	assign lim14  = GW'(({1'b0, lim16} + 17'd2) >> 2);
	assign g_lo   = tgtl_pkg::GAIN_ONE - lim14;
	assign g_hi   = tgtl_pkg::GAIN_ONE + lim14;
	assign diff   = $signed({1'b0, target_q}) - $signed({3'b000, gain_res_q});
	assign prod_d = diff * $signed({1'b0, step_q});

	assign mag     = prod_q[35] ? 36'(-prod_q) : 36'(prod_q);
	assign mag_rnd = mag + 36'd32768;
	assign g_ext   = $signed({7'd0, gain_res_q});
	assign adj     = $signed({2'b00, mag_rnd[35:16]});
	assign g_sum   = prod_q[35] ? (g_ext - adj) : (g_ext + adj);

	always_comb begin
		if (g_sum < $signed({7'd0, g_lo})) begin
			gain_new = g_lo;
		end else if (g_sum > $signed({7'd0, g_hi})) begin
			gain_new = g_hi;
		end else begin
			gain_new = g_sum[GW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			gain_res_q    <= eval_gain;
			outcome_res_q <= eval_outcome;
			band_q        <= eval_band;
			num_q         <= num;
			aspd_q        <= aspd;
		end else if (cmd.adj) begin
			gain_res_q <= gain_new;
		end
		if (cmd.tgt_load) begin
			target_q <= (div_quot < tgtl_pkg::TARGET_MIN) ? tgtl_pkg::TARGET_MIN : div_quot;
		end
		if (cmd.step_load) begin
			step_q <= div_quot;
		end
		if (cmd.mul) begin
			prod_q <= prod_d;
		end
		if (cmd.res_load) begin
			gain_out_q    <= gain_res_q;
			outcome_out_q <= outcome_res_q;
			band_out_q    <= band_q;
		end
	end

	assign status.learn    = learn;
	assign status.div_done = div_done;

	assign gain_value = gain_out_q;
	assign outcome    = outcome_out_q;
	assign band_used  = band_out_q;

	a_gain_in_band: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.adj |-> (gain_new >= g_lo && gain_new <= g_hi))
		else $error("updated gain outside trim limits");

endmodule

// ----- rtl/core/thruster_gain_trim_learner.sv -----
// ----------------------------------------------------------------------------
// thruster_gain_trim_learner
// Adaptive per-thruster gain trim with forward and reverse gains per motor.
// ----------------------------------------------------------------------------
// One request is handled at a time and gives one result. Queries, clears,
// bad indices and rejected update samples go from evaluation straight to
// the result register; an update that learns first runs two 17-step
// restoring divisions (target ratio, then learning step) one after the
// other on a single shared divider, followed by a multiply and an adjust
// step. The result sits in an output register, so the next request is
// taken as soon as the current one has been handed to that register.
// Configuration writes take effect at once and belong in idle periods.
// ----------------------------------------------------------------------------
module thruster_gain_trim_learner #(
	parameter int MOTOR_COUNT = tgtl_pkg::MOTOR_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tgtl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tgtl_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic [tgtl_pkg::MODE_W-1:0]         mode,
	input  logic [tgtl_pkg::MOTOR_W-1:0]        motor,
	input  logic signed [tgtl_pkg::DUTY_W-1:0]  duty,
	input  logic signed [tgtl_pkg::SPEED_W-1:0] speed_rpm,
	input  logic                                telemetry_present,
	input  logic [tgtl_pkg::INTERVAL_W-1:0]     interval_ms,
	input  logic                                learn_allowed,
	input  logic                                forward_band,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [tgtl_pkg::GAIN_W-1:0]         gain_value,
	output logic [tgtl_pkg::OUTCOME_W-1:0]      outcome,
	output logic                                band_used
);

	tgtl_pkg::cmd_t    cmd;
	tgtl_pkg::status_t status;

	tgtl_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd),
		.status       (status)
	);

	tgtl_dp #(
		.MOTOR_COUNT (MOTOR_COUNT)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.mode              (mode),
		.motor             (motor),
		.duty              (duty),
		.speed_rpm         (speed_rpm),
		.telemetry_present (telemetry_present),
		.interval_ms       (interval_ms),
		.learn_allowed     (learn_allowed),
		.forward_band      (forward_band),
		.cmd               (cmd),
		.status            (status),
		.gain_value        (gain_value),
		.outcome           (outcome),
		.band_used         (band_used)
	);

endmodule

// ----- bench/trim_gain_checker.sv -----
// ----------------------------------------------------------------------------
// trim_gain_checker
// Watches the request, result and register ports of the gain trim learner,
// keeps its own copy of the per-thruster gain table and the previous duties,
// works out the answer due for every accepted request and compares each
// accepted result with the oldest answer still awaited.
// ----------------------------------------------------------------------------
module trim_gain_checker #(
	parameter int MOTOR_COUNT = tgtl_pkg::MOTOR_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tgtl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tgtl_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                item_valid,
	input  logic                                item_ready,
	input  logic [tgtl_pkg::MODE_W-1:0]         mode,
	input  logic [tgtl_pkg::MOTOR_W-1:0]        motor,
	input  logic signed [tgtl_pkg::DUTY_W-1:0]  duty,
	input  logic signed [tgtl_pkg::SPEED_W-1:0] speed_rpm,
	input  logic                                telemetry_present,
	input  logic [tgtl_pkg::INTERVAL_W-1:0]     interval_ms,
	input  logic                                learn_allowed,
	input  logic                                forward_band,
	input  logic                                result_valid,
	input  logic                                result_ready,
	input  logic [tgtl_pkg::GAIN_W-1:0]         gain_value,
	input  logic [tgtl_pkg::OUTCOME_W-1:0]      outcome,
	input  logic                                band_used,
	output int                                  fault_count,
	output int                                  pending_count
);
	import tgtl_pkg::*;

	typedef struct packed {
		logic [GAIN_W-1:0]    gain;
		logic [OUTCOME_W-1:0] code;
		logic                 band;
	} gain_answer_t;

	gain_answer_t expected_answers[$];

	logic              trim_on;
	logic [RPM_W-1:0]  full_rpm;
	logic [TAU_W-1:0]  tau_cfg;
	logic [LIM_W-1:0]  lim_cfg;
	int                gain_store [16][2];
	int                last_duty [16];
	int                mismatches;

	// one learning step on the selected gain, returns the new gain
	function automatic longint trim_learn(input int mot, input int band, input longint adur,
			input longint aspd, input longint rpm, input longint ivl);
		longint tau, lim14, den, target, step_q16, delta, g;
		tau = (tau_cfg > TAU_MIN) ? longint'(tau_cfg) : longint'(TAU_DEFAULT);
		lim14 = ((lim_cfg > LIM_MAX) ? longint'(LIM_MAX) : longint'(lim_cfg));
		lim14 = (lim14 + 2) >> 2;
		if (aspd == 0) begin
			target = 65536;
		end else begin
			den = 2 * aspd;
			target = (rpm * adur + den / 2) / den;
			if (target < 4096) target = 4096;
			if (target > 65536) target = 65536;
		end
		step_q16 = (ivl * 65536 + tau / 2) / tau;
		if (step_q16 > 65536) step_q16 = 65536;
		g = gain_store[mot][band];
		delta = (target - g) * step_q16;
		if (delta >= 0) g = g + (delta + 32768) / 65536;
		else g = g - (-delta + 32768) / 65536;
		if (g < 16384 - lim14) g = 16384 - lim14;
		if (g > 16384 + lim14) g = 16384 + lim14;
		gain_store[mot][band] = int'(g);
		return g;
	endfunction

	function automatic gain_answer_t trim_predict(input logic [MODE_W-1:0] m,
			input logic [MOTOR_W-1:0] mot, input logic signed [DUTY_W-1:0] d,
			input logic signed [SPEED_W-1:0] spd, input logic tel,
			input logic [INTERVAL_W-1:0] ivl, input logic allow, input logic fwd);
		gain_answer_t ans;
		int dv, sv, band;
		longint adur, aspd, slew, rpm;
		dv = d;
		sv = spd;
		band = (m == MODE_RAW) ? int'(!fwd) : int'(dv < 0);
		ans.gain = GAIN_ONE;
		ans.code = OUT_ANSWERED;
		ans.band = band[0];
		if (m == MODE_CLEAR) begin
			for (int i = 0; i < 16; i++) begin
				gain_store[i][0] = GAIN_ONE;
				gain_store[i][1] = GAIN_ONE;
				last_duty[i] = 0;
			end
			ans.band = 1'b0;
			ans.code = OUT_CLEARED;
		end else if (mot >= MOTOR_COUNT) begin
			ans.code = OUT_BAD_INDEX;
		end else if (m == MODE_RAW) begin
			ans.gain = gain_store[mot][band];
		end else if (m == MODE_GAIN) begin
			if (trim_on) ans.gain = gain_store[mot][band];
			else ans.code = OUT_OFF;
		end else begin
			adur = (dv < 0) ? -dv : dv;
			aspd = (sv < 0) ? -sv : sv;
			slew = longint'(dv) - longint'(last_duty[mot]);
			if (slew < 0) slew = -slew;
			rpm = (full_rpm > RPM_MIN) ? longint'(full_rpm) : longint'(RPM_DEFAULT);
			last_duty[mot] = dv;
			ans.gain = gain_store[mot][band];
			if (!trim_on || !allow || ivl == 0) ans.code = OUT_OFF;
			else if (!tel) ans.code = OUT_NO_TELEM;
			else if (adur * 20 < 98304) ans.code = OUT_LOW_DUTY;
			else if (slew * 20 > 32768) ans.code = OUT_TRANSIENT;
			else if (rpm * adur < 32768) ans.code = OUT_LOW_PRED;
			else if (((dv >= 0) != (sv >= 0)) && aspd * 20 > rpm) ans.code = OUT_REVERSAL;
			else begin
				ans.gain = GAIN_W'(trim_learn(int'(mot), band, adur, aspd, rpm, longint'(ivl)));
				ans.code = OUT_LEARNED;
			end
		end
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gain_answer_t due;
		if (!arst_n) begin
			trim_on = 1'b0;
			full_rpm = RPM_DEFAULT;
			tau_cfg = TAU_DEFAULT;
			lim_cfg = '0;
			for (int i = 0; i < 16; i++) begin
				gain_store[i][0] = GAIN_ONE;
				gain_store[i][1] = GAIN_ONE;
				last_duty[i] = 0;
			end
			expected_answers.delete();
			mismatches = 0;
			fault_count <= 0;
			pending_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ENABLE:   trim_on = cfg_data[0];
					CFG_FULL_RPM: full_rpm = cfg_data[RPM_W-1:0];
					CFG_TAU:      tau_cfg = cfg_data[TAU_W-1:0];
					CFG_LIMIT:    lim_cfg = cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (expected_answers.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with no request outstanding: gain %0d outcome %0d band %0d",
							$realtime, gain_value, outcome, band_used);
				end else begin
					due = expected_answers.pop_front();
					if (gain_value !== due.gain || outcome !== due.code || band_used !== due.band) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch: gain exp %0d got %0d, outcome exp %0d got %0d, band exp %0d got %0d",
								$realtime, due.gain, gain_value, due.code, outcome,
								due.band, band_used);
					end
				end
			end
			if (item_valid && item_ready)
				expected_answers.push_back(trim_predict(mode, motor, duty, speed_rpm,
					telemetry_present, interval_ms, learn_allowed, forward_band));
			fault_count <= mismatches;
			pending_count <= expected_answers.size();
		end
	end

endmodule

// ----- bench/thruster_gain_trim_learner_test.sv -----
// ----------------------------------------------------------------------------
// thruster_gain_trim_learner_test
// Drives the gain trim learner with a short directed set of requests (every
// mode, bad indices, each rejection reason, saturating step and target) and
// then with phases of random requests under several register settings,
// mostly steady per-thruster duty sequences that let the gains learn, mixed
// with raw noise. Both sides idle at random; once the result side holds off
// for a long stretch. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module thruster_gain_trim_learner_test;
	import tgtl_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    item_valid = 1'b0;
	logic                    item_ready;
	logic [MODE_W-1:0]       mode = MODE_GAIN;
	logic [MOTOR_W-1:0]      motor = '0;
	logic [DUTY_W-1:0]       duty = '0;
	logic [SPEED_W-1:0]      speed_rpm = '0;
	logic                    telemetry_present = 1'b0;
	logic [INTERVAL_W-1:0]   interval_ms = '0;
	logic                    learn_allowed = 1'b0;
	logic                    forward_band = 1'b0;
	logic                    result_valid;
	logic                    result_ready = 1'b0;
	logic [GAIN_W-1:0]       gain_value;
	logic [OUTCOME_W-1:0]    outcome;
	logic                    band_used;

	int   fault_count;
	int   pending_count;
	int   cycle_count = 0;
	int   cur_rpm = RPM_DEFAULT;
	int   lane_duty [16];
	logic idling_on = 1'b1;
	logic hold_req = 1'b0;

	thruster_gain_trim_learner uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.item_valid        (item_valid),
		.item_ready        (item_ready),
		.mode              (mode),
		.motor             (motor),
		.duty              (duty),
		.speed_rpm         (speed_rpm),
		.telemetry_present (telemetry_present),
		.interval_ms       (interval_ms),
		.learn_allowed     (learn_allowed),
		.forward_band      (forward_band),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.gain_value        (gain_value),
		.outcome           (outcome),
		.band_used         (band_used)
	);

	trim_gain_checker check (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.item_valid        (item_valid),
		.item_ready        (item_ready),
		.mode              (mode),
		.motor             (motor),
		.duty              (duty),
		.speed_rpm         (speed_rpm),
		.telemetry_present (telemetry_present),
		.interval_ms       (interval_ms),
		.learn_allowed     (learn_allowed),
		.forward_band      (forward_band),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.gain_value        (gain_value),
		.outcome           (outcome),
		.band_used         (band_used),
		.fault_count       (fault_count),
		.pending_count     (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int   hold_left;
		logic hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_seen) begin
				hold_seen = 1'b1;
				hold_left = 200;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= !(idling_on && $urandom_range(0, 99) < 10);
			end
		end
	end

	task automatic offer(input logic [MODE_W-1:0] m, input logic [MOTOR_W-1:0] mot,
			input logic [DUTY_W-1:0] d, input logic [SPEED_W-1:0] spd, input logic tel,
			input logic [INTERVAL_W-1:0] ivl, input logic allow, input logic fwd);
		while (idling_on && $urandom_range(0, 99) < 10) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid        <= 1'b1;
		mode              <= m;
		motor             <= mot;
		duty              <= d;
		speed_rpm         <= spd;
		telemetry_present <= tel;
		interval_ms       <= ivl;
		learn_allowed     <= allow;
		forward_band      <= fwd;
		do @(posedge clk); while (!item_ready);
	endtask

	// wait until every request has been answered
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	task automatic set_trim(input logic en, input logic [RPM_W-1:0] rpm,
			input logic [TAU_W-1:0] tau, input logic [LIM_W-1:0] lim);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ENABLE;
		cfg_data  <= CFG_DATA_W'(en);
		@(posedge clk);
		cfg_index <= CFG_FULL_RPM;
		cfg_data  <= CFG_DATA_W'(rpm);
		@(posedge clk);
		cfg_index <= CFG_TAU;
		cfg_data  <= tau;
		@(posedge clk);
		cfg_index <= CFG_LIMIT;
		cfg_data  <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_rpm = rpm;
	endtask

	task automatic offer_random();
		int               k, mot, d, mag, spd, rpm_eff, ivl;
		logic             tel, allow;
		logic [MODE_W-1:0] m;
		k = $urandom_range(0, 99);
		if (k < 15) begin
			m = $urandom;
			if (m == MODE_CLEAR && $urandom_range(0, 3) != 0) m = MODE_UPDATE;
			offer(m, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		end else if (k < 27) begin
			m = $urandom_range(0, 1) ? MODE_GAIN : MODE_RAW;
			offer(m, $urandom_range(0, MOTOR_COUNT_DEF), $urandom, $urandom, 1'b1, '0, 1'b0,
				$urandom);
		end else begin
			// steady duty sequence on one thruster
			mot = $urandom_range(0, MOTOR_COUNT_DEF - 1);
			d = lane_duty[mot];
			if ((d > -6000 && d < 6000) || $urandom_range(0, 19) == 0) begin
				d = int'($urandom_range(6000, 32767));
				if ($urandom_range(0, 1)) d = -d - 1;
			end else begin
				d = d + int'($urandom_range(0, 3300)) - 1650;
				if (d > 32767) d = 32767;
				if (d < -32768) d = -32768;
			end
			rpm_eff = (cur_rpm > 1) ? cur_rpm : int'(RPM_DEFAULT);
			mag = (rpm_eff * ((d < 0) ? -d : d)) >>> 15;
			mag = mag * int'($urandom_range(30, 300)) / 100;
			if (mag > 32767) mag = 32767;
			if ($urandom_range(0, 29) == 0) mag = 0;
			spd = (d < 0) ? -mag : mag;
			if ($urandom_range(0, 19) == 0) spd = -spd;
			ivl = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535))
				: int'($urandom_range(20, 400));
			tel = $urandom_range(0, 19) != 0;
			allow = $urandom_range(0, 19) != 0;
			lane_duty[mot] = d;
			offer(MODE_UPDATE, mot, d, spd, tel, ivl, allow, $urandom);
		end
	endtask

	task automatic run_phase(input logic en, input logic [RPM_W-1:0] rpm,
			input logic [TAU_W-1:0] tau, input logic [LIM_W-1:0] lim, input int count,
			input logic idle, input logic hold);
		settle();
		idling_on <= idle;
		set_trim(en, rpm, tau, lim);
		if (hold) hold_req <= 1'b1;
		repeat (count) offer_random();
	endtask

	initial begin
		for (int i = 0; i < 16; i++) lane_duty[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// trim disabled after reset
		offer(MODE_GAIN,   4'd0,  16'h4000, 16'd1000, 1'b1, 16'd100, 1'b1, 1'b1);
		offer(MODE_RAW,    4'd0,  16'h4000, 16'd1000, 1'b1, 16'd100, 1'b1, 1'b0);
		offer(MODE_UPDATE, 4'd1,  16'h7FFF, 16'd3000, 1'b1, 16'd100, 1'b1, 1'b1);
		offer(MODE_GAIN,   4'd15, 16'h8000, 16'h8000, 1'b1, 16'd100, 1'b1, 1'b1);
		offer(MODE_RAW,    4'd8,  16'h0000, 16'h7FFF, 1'b0, 16'hFFFF, 1'b0, 1'b1);
		settle();
		set_trim(1'b1, 15'd3600, 16'd1000, 16'hFFFF);

		// each rejection reason but a low prediction, and learning in both bands
		offer(MODE_UPDATE, 4'd0, 16'h6000, 16'd2000, 1'b1, 16'd100, 1'b1, 1'b0);
		offer(MODE_UPDATE, 4'd0, 16'h6000, 16'd2000, 1'b1, 16'd100, 1'b1, 1'b0);
		offer(MODE_UPDATE, 4'd0, 16'h6000, 16'd0,    1'b1, 16'hFFFF, 1'b1, 1'b0);
		offer(MODE_UPDATE, 4'd0, 16'h6000, 16'd2000, 1'b0, 16'd100, 1'b1, 1'b0);
		offer(MODE_UPDATE, 4'd0, 16'h1000, 16'd2000, 1'b1, 16'd100, 1'b1, 1'b0);
		offer(MODE_UPDATE, 4'd0, 16'h6000, 16'd2000, 1'b1, 16'd100, 1'b1, 1'b0);
		offer(MODE_UPDATE, 4'd0, 16'h6000, -16'sd3000, 1'b1, 16'd100, 1'b1, 1'b0);
		offer(MODE_UPDATE, 4'd0, 16'h6000, 16'd2000, 1'b1, 16'd100, 1'b0, 1'b0);
		offer(MODE_UPDATE, 4'd0, 16'h6000, 16'd2000, 1'b1, 16'd0,   1'b1, 1'b0);
		offer(MODE_UPDATE, 4'd2, 16'h8000, 16'h8000, 1'b1, 16'd500, 1'b1, 1'b0);
		offer(MODE_UPDATE, 4'd2, 16'h8000, 16'h8000, 1'b1, 16'd500, 1'b1, 1'b0);
		offer(MODE_GAIN,   4'd0, 16'h6000, 16'd0,    1'b0, 16'd0,   1'b0, 1'b0);
		offer(MODE_RAW,    4'd2, 16'h0000, 16'd0,    1'b0, 16'd0,   1'b0, 1'b0);
		offer(MODE_CLEAR,  4'd5, 16'h8000, 16'd0,    1'b0, 16'd0,   1'b0, 1'b1);
		offer(MODE_RAW,    4'd2, 16'h0000, 16'd0,    1'b0, 16'd0,   1'b0, 1'b0);
		settle();
		set_trim(1'b1, 15'd2, 16'hFFFF, 16'd0);

		// prediction too small at a tiny full-speed setting
		offer(MODE_UPDATE, 4'd3, 16'h2000, 16'h7FFF, 1'b1, 16'd100, 1'b1, 1'b0);
		offer(MODE_UPDATE, 4'd3, 16'h2000, 16'h7FFF, 1'b1, 16'd100, 1'b1, 1'b0);

		run_phase(1'b1, 15'd3600, 16'd4000, 16'd8192, 320, 1'b1, 1'b1);
		run_phase(1'b1, 15'd0, 16'd0, 16'hFFFF, 320, 1'b0, 1'b0);
		run_phase(1'b1, 15'd32767, 16'd201, 16'd58982, 320, 1'b1, 1'b0);
		run_phase(1'b0, 15'd1, 16'd200, 16'd0, 250, 1'b1, 1'b0);
		run_phase(1'b1, $urandom_range(2, 32767), 16'hFFFF, $urandom, 320, 1'b1, 1'b0);
		run_phase(1'b1, 15'd4, $urandom_range(201, 3000), $urandom, 300, 1'b1, 1'b0);

		settle();
		repeat (64) @(posedge clk);
		if (fault_count == 0 && pending_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
